### design/qfuf_pkg.sv
`default_nettype none

package qfuf_pkg;

    localparam int ACTION_W             = 2;
    localparam int ELEM_W               = 6;
    localparam int ID_W                 = 6;
    localparam int COUNT_W              = 7;
    localparam int S_TDATA_W            = 16;
    localparam int M_TDATA_W            = 16;
    localparam int MAX_ELEMENTS_DEFAULT = 64;
    localparam int NUM_ELEMENTS_RESET   = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_RESTART   = 2'd0,
        ACT_FIND      = 2'd1,
        ACT_CONNECTED = 2'd2,
        ACT_UNION     = 2'd3
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture the incoming transaction
        logic sample_ids;  // read ids of p and q, range check
        logic apply;       // update table and result register
    } dp_cmd_t;

endpackage

`default_nettype wire

### design/qfuf_ctrl.sv
`default_nettype none

module qfuf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output qfuf_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_APPLY) && out_free);
        cmd.load_item  = s_valid && s_ready;
        cmd.sample_ids = (state_reg == ST_READ);
        cmd.apply      = (state_reg == ST_APPLY) && out_free;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = s_valid ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### design/qfuf_datapath.sv
`default_nettype none

module qfuf_datapath #(
    parameter int MAX_ELEMENTS = qfuf_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire qfuf_pkg::dp_cmd_t             cmd,
    input  wire logic                          cfg_wr_en,
    input  wire logic [qfuf_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  wire logic [qfuf_pkg::ACTION_W-1:0] in_action,
    input  wire logic [qfuf_pkg::ELEM_W-1:0]   in_elem_p,
    input  wire logic [qfuf_pkg::ELEM_W-1:0]   in_elem_q,
    output logic [qfuf_pkg::ID_W-1:0]          out_set_id,
    output logic                               out_same_set,
    output logic                               out_merged,
    output logic [qfuf_pkg::COUNT_W-1:0]       out_set_count,
    output logic                               out_index_error
);

    localparam int CW          = qfuf_pkg::COUNT_W;
    localparam int IW          = qfuf_pkg::ID_W;
    localparam int EW          = qfuf_pkg::ELEM_W;
    localparam int ADDR_SPAN   = 1 << EW;
    localparam int TABLE_DEPTH = (MAX_ELEMENTS < ADDR_SPAN) ? MAX_ELEMENTS : ADDR_SPAN;
    localparam int COUNT_MAX   = (1 << CW) - 1;
    localparam logic [CW-1:0] N_CAP =
        CW'((MAX_ELEMENTS < COUNT_MAX) ? MAX_ELEMENTS : COUNT_MAX);
    localparam logic [CW-1:0] N_RESET =
        CW'((qfuf_pkg::NUM_ELEMENTS_RESET < MAX_ELEMENTS) ?
            qfuf_pkg::NUM_ELEMENTS_RESET : MAX_ELEMENTS);

    qfuf_pkg::action_t act_reg;
    logic [EW-1:0]     p_reg, q_reg;
    logic [IW-1:0]     pid_reg, qid_reg, pid_sel, qid_sel;
    logic              err_reg, err_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     sets_left_reg, sets_left_next;
    logic [IW-1:0]     cell_reg  [TABLE_DEPTH];
    logic [IW-1:0]     cell_next [TABLE_DEPTH];
    logic              same_ids;

    logic [IW-1:0]     set_id_reg, set_id_next;
    logic              same_reg, same_next;
    logic              merged_reg, merged_next;
    logic              oerr_reg, oerr_next;

    // Clamp the element count on write
    always_comb begin
        if (cfg_wr_data == '0) begin
            n_next = CW'(1);
        end else if (cfg_wr_data > N_CAP) begin
            n_next = N_CAP;
        end else begin
            n_next = cfg_wr_data;
        end
    end

    // Per-cell select of the p and q ids, or-reduced
    always_comb begin
        pid_sel = '0;
        qid_sel = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (p_reg == EW'(i)) pid_sel = pid_sel | cell_reg[i];
            if (q_reg == EW'(i)) qid_sel = qid_sel | cell_reg[i];
        end
    end

    always_comb begin
        err_next = (act_reg != qfuf_pkg::ACT_RESTART) &&
                   ((CW'(p_reg) >= n_reg) ||
                    ((act_reg != qfuf_pkg::ACT_FIND) && (CW'(q_reg) >= n_reg)));
    end

    assign same_ids = (pid_reg == qid_reg);

    // Apply: relabel cells in parallel and form the result
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            cell_next[i] = cell_reg[i];
        end
        sets_left_next = sets_left_reg;
        set_id_next    = '0;
        same_next      = 1'b0;
        merged_next    = 1'b0;
        oerr_next      = 1'b0;
        if (act_reg == qfuf_pkg::ACT_RESTART) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                cell_next[i] = IW'(i);
            end
            sets_left_next = n_reg;
        end else if (err_reg) begin
            oerr_next = 1'b1;
        end else begin
            set_id_next = pid_reg;
            if (act_reg != qfuf_pkg::ACT_FIND) begin
                same_next = same_ids;
            end
            if ((act_reg == qfuf_pkg::ACT_UNION) && !same_ids) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if ((CW'(i) < n_reg) && (cell_reg[i] == pid_reg)) begin
                        cell_next[i] = qid_reg;
                    end
                end
                if (sets_left_reg != '0) begin
                    sets_left_next = sets_left_reg - CW'(1);
                end
                merged_next = 1'b1;
                set_id_next = qid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg         <= N_RESET;
            sets_left_reg <= N_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                cell_reg[i] <= IW'(i);
            end
        end else begin
            if (cfg_wr_en) begin
                n_reg <= n_next;
            end
            if (cmd.apply) begin
                sets_left_reg <= sets_left_next;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    cell_reg[i] <= cell_next[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg <= qfuf_pkg::action_t'(in_action);
            p_reg   <= in_elem_p;
            q_reg   <= in_elem_q;
        end
        if (cmd.sample_ids) begin
            pid_reg <= pid_sel;
            qid_reg <= qid_sel;
            err_reg <= err_next;
        end
        if (cmd.apply) begin
            set_id_reg <= set_id_next;
            same_reg   <= same_next;
            merged_reg <= merged_next;
            oerr_reg   <= oerr_next;
        end
    end

    assign out_set_id      = set_id_reg;
    assign out_same_set    = same_reg;
    assign out_merged      = merged_reg;
    assign out_set_count   = sets_left_reg;
    assign out_index_error = oerr_reg;

endmodule

`default_nettype wire

### design/quick_find_union_find_unit.sv
`default_nettype none

// Quick-find disjoint-set unit. Every element keeps its set id in a cell of
// its own; a union compares all cells against p's id and relabels the hits
// with q's id in parallel. Each input transaction has a read step, which
// selects the ids of p and q from the cell row and range-checks the indexes,
// and an apply step, which relabels the cells and loads the result register
// and raises m_axis_tvalid. The next input can be taken in the same cycle
// the result is loaded; a stalled result port holds the unit in its apply
// step. Reset puts the table into singleton sets directly, so no clearing
// pass is needed. The element count register is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while no transaction is in
// flight, as the block itself does not enforce this. The value is clamped to
// 1..MAX_ELEMENTS and takes effect in the set count on restart.
module quick_find_union_find_unit #(
    parameter int MAX_ELEMENTS = qfuf_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // element count register
    input  wire logic                           cfg_wr_en,
    input  wire logic [qfuf_pkg::COUNT_W-1:0]   cfg_wr_data,

    // input transactions
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [qfuf_pkg::S_TDATA_W-1:0] s_axis_tdata,  // elem_p, elem_q, zero pad
    input  wire logic [qfuf_pkg::ACTION_W-1:0]  s_axis_tuser,  // action

    // result transactions
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [qfuf_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // set_id, same_set, merged,
                                                               // set_count, zero pad
    output logic [0:0]                          m_axis_tuser   // index_error
);

    localparam int EW = qfuf_pkg::ELEM_W;

    qfuf_pkg::dp_cmd_t                cmd;
    logic [qfuf_pkg::ID_W-1:0]        set_id;
    logic                             same_set;
    logic                             merged;
    logic [qfuf_pkg::COUNT_W-1:0]     set_count;
    logic                             index_error;

    // Sequencer: owns the handshakes and the result valid flag
    qfuf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    // Cell row, count registers and result register
    qfuf_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_action       (s_axis_tuser),
        .in_elem_p       (s_axis_tdata[EW-1:0]),
        .in_elem_q       (s_axis_tdata[2*EW-1:EW]),
        .out_set_id      (set_id),
        .out_same_set    (same_set),
        .out_merged      (merged),
        .out_set_count   (set_count),
        .out_index_error (index_error)
    );

    // Pack the result, first field in the low bits
    assign m_axis_tdata = {1'b0, set_count, merged, same_set, set_id};
    assign m_axis_tuser = index_error;

    // One transaction in flight: the ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous transaction still in progress");

    // A merge only happens between distinct, in-range sets
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && merged) |-> (!same_set && !index_error))
        else $error("merge reported with same_set or index_error");

    // An index error leaves id and flags cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && index_error) |-> (set_id == '0 && !same_set && !merged))
        else $error("index error result carries nonzero fields");

    // A merge lowers the count by at most one and never raises it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && !($past(!aresetn))) |=> (set_count <= $past(set_count)) || !merged)
        else $error("merge raised the set count");

endmodule

`default_nettype wire

### bench/quick_find_union_find_unit_test.sv
`default_nettype none

// Self-checking bench for the quick-find union-find unit.
// Feed a queue of actions through a bursty driver, predict each result at
// the moment its transaction is accepted, and compare it with what comes out
// of the result port while the receiver stalls on its own pattern. The
// element count register is rewritten between phases while nothing is in
// flight, walking through clamped, small, full and random settings.
module quick_find_union_find_unit_test;

    localparam int ELEM_W       = qfuf_pkg::ELEM_W;
    localparam int ID_W         = qfuf_pkg::ID_W;
    localparam int COUNT_W      = qfuf_pkg::COUNT_W;
    localparam int ACTION_W     = qfuf_pkg::ACTION_W;
    localparam int S_TDATA_W    = qfuf_pkg::S_TDATA_W;
    localparam int M_TDATA_W    = qfuf_pkg::M_TDATA_W;
    localparam int TABLE_SIZE   = qfuf_pkg::MAX_ELEMENTS_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;   // far above the slowest legal run
    localparam int RANDOM_PHASE = 100;

    typedef struct packed {
        qfuf_pkg::action_t act;
        logic [ELEM_W-1:0] p;
        logic [ELEM_W-1:0] q;
    } action_item_t;

    typedef struct packed {
        logic [ID_W-1:0]    set_id;
        logic               same_set;
        logic               merged;
        logic [COUNT_W-1:0] set_count;
        logic               index_error;
    } uf_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // elem_p, elem_q, zero pad
    logic [ACTION_W-1:0]  s_axis_tuser  = '0;   // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // set_id, same_set, merged, set_count, pad
    logic [0:0]           m_axis_tuser;         // index_error

    // Bench copy of the unit's state
    logic [ID_W-1:0]    id_table [TABLE_SIZE];
    int                 sets_left;
    logic [COUNT_W-1:0] count_reg;

    action_item_t pending_actions [$];
    uf_result_t   expected_results [$];

    int mismatches = 0;
    int cycles     = 0;

    // Sender burst shaping and receiver stall pattern
    int burst_left = 0;
    int gap_left   = 0;
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;

    quick_find_union_find_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Register value clamped to 1..TABLE_SIZE
    function automatic int active_elements();
        if (count_reg == 0)
            return 1;
        if (count_reg > TABLE_SIZE)
            return TABLE_SIZE;
        return count_reg;
    endfunction

    // Put every entry, also those beyond the count, back into its own set
    function automatic void restart_sets();
        for (int i = 0; i < TABLE_SIZE; i++)
            id_table[i] = ID_W'(i);
        sets_left = active_elements();
    endfunction

    // Apply one action to the bench table and return the result it causes
    function automatic uf_result_t apply_action(action_item_t it);
        uf_result_t      res;
        int              n;
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] qid;
        n   = active_elements();
        res = '0;
        if (it.act == qfuf_pkg::ACT_RESTART) begin
            restart_sets();
        end else if (it.p >= n || (it.act != qfuf_pkg::ACT_FIND && it.q >= n)) begin
            res.index_error = 1'b1;
        end else if (it.act == qfuf_pkg::ACT_FIND) begin
            res.set_id = id_table[it.p];
        end else begin
            pid          = id_table[it.p];
            qid          = id_table[it.q];
            res.same_set = (pid == qid);
            if (it.act == qfuf_pkg::ACT_UNION && pid != qid) begin
                // relabel only inside the active range
                for (int i = 0; i < n; i++)
                    if (id_table[i] == pid)
                        id_table[i] = qid;
                if (sets_left > 0)
                    sets_left--;
                res.merged = 1'b1;
            end
            res.set_id = id_table[it.p];
        end
        res.set_count = COUNT_W'(sets_left);
        return res;
    endfunction

    task automatic push_action(qfuf_pkg::action_t act, int p, int q);
        action_item_t it;
        it.act = act;
        it.p   = ELEM_W'(p);
        it.q   = ELEM_W'(q);
        pending_actions.push_back(it);
    endtask

    // Mostly in-range indexes with unions weighted up, some restarts and
    // some indexes drawn from the whole field so that errors show up
    function automatic action_item_t random_action(int n);
        action_item_t it;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.act = qfuf_pkg::ACT_RESTART;
        else if (pick < 28)
            it.act = qfuf_pkg::ACT_FIND;
        else if (pick < 50)
            it.act = qfuf_pkg::ACT_CONNECTED;
        else
            it.act = qfuf_pkg::ACT_UNION;
        it.p = ($urandom_range(0, 9) == 0) ? ELEM_W'($urandom_range(0, TABLE_SIZE - 1))
                                           : ELEM_W'($urandom_range(0, n - 1));
        it.q = ($urandom_range(0, 9) == 0) ? ELEM_W'($urandom_range(0, TABLE_SIZE - 1))
                                           : ELEM_W'($urandom_range(0, n - 1));
        return it;
    endfunction

    // Hold until the queue is drained and every result has arrived, then let
    // the pipeline settle
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pending_actions.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        count_reg = value;
        @(negedge aclk);
    endtask

    task automatic random_phase(logic [COUNT_W-1:0] value, int items);
        write_count(value);
        if ($urandom_range(0, 1) == 1)
            push_action(qfuf_pkg::ACT_RESTART, $urandom_range(0, 63), $urandom_range(0, 63));
        for (int i = 0; i < items; i++)
            pending_actions.push_back(random_action(active_elements()));
    endtask

    // Stimulus: directed actions first, then random phases under several
    // element counts
    initial begin
        count_reg = COUNT_W'(qfuf_pkg::NUM_ELEMENTS_RESET);
        restart_sets();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Full table: extreme indexes, merge, repeated merge, self compare
        push_action(qfuf_pkg::ACT_FIND, 0, 0);
        push_action(qfuf_pkg::ACT_FIND, 63, 63);
        push_action(qfuf_pkg::ACT_CONNECTED, 0, 63);
        push_action(qfuf_pkg::ACT_CONNECTED, 7, 7);
        push_action(qfuf_pkg::ACT_UNION, 0, 63);
        push_action(qfuf_pkg::ACT_UNION, 63, 0);
        push_action(qfuf_pkg::ACT_UNION, 5, 5);
        push_action(qfuf_pkg::ACT_UNION, 1, 2);
        push_action(qfuf_pkg::ACT_UNION, 2, 63);
        push_action(qfuf_pkg::ACT_CONNECTED, 1, 0);
        push_action(qfuf_pkg::ACT_RESTART, 63, 0);

        // Zero clamps to a single element: everything but 0 is out of range
        write_count(7'd0);
        push_action(qfuf_pkg::ACT_RESTART, 0, 0);
        push_action(qfuf_pkg::ACT_FIND, 1, 0);
        push_action(qfuf_pkg::ACT_FIND, 63, 0);
        push_action(qfuf_pkg::ACT_CONNECTED, 0, 1);
        push_action(qfuf_pkg::ACT_UNION, 63, 0);
        push_action(qfuf_pkg::ACT_UNION, 0, 0);

        // Enlarge the count without a restart so the set count runs out
        write_count(7'd2);
        push_action(qfuf_pkg::ACT_RESTART, 0, 0);
        write_count(7'd64);
        push_action(qfuf_pkg::ACT_UNION, 2, 3);
        push_action(qfuf_pkg::ACT_UNION, 4, 5);
        push_action(qfuf_pkg::ACT_UNION, 6, 7);
        push_action(qfuf_pkg::ACT_FIND, 7, 0);

        random_phase(7'd127, RANDOM_PHASE);
        random_phase(7'd5, RANDOM_PHASE);
        random_phase(7'd64, RANDOM_PHASE);
        random_phase(7'd1, RANDOM_PHASE);
        random_phase(7'd16, RANDOM_PHASE);
        random_phase(7'd65, RANDOM_PHASE);
        random_phase(7'd33, RANDOM_PHASE);
        random_phase(COUNT_W'($urandom_range(1, 127)), RANDOM_PHASE);
        random_phase(COUNT_W'($urandom_range(2, 12)), RANDOM_PHASE);
        random_phase(7'd3, RANDOM_PHASE);

        wait_idle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Driver: predict on each accepted transaction, then advance to the next
    // pending item unless the current burst has run into a gap
    always @(posedge aclk) begin
        action_item_t nxt;
        action_item_t sent;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent.act = qfuf_pkg::action_t'(s_axis_tuser);
                sent.p   = s_axis_tdata[ELEM_W-1:0];
                sent.q   = s_axis_tdata[2*ELEM_W-1:ELEM_W];
                expected_results.push_back(apply_action(sent));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_actions.size() != 0) begin
                    nxt = pending_actions.pop_front();
                    s_axis_tdata  <= {{(S_TDATA_W - 2*ELEM_W){1'b0}}, nxt.q, nxt.p};
                    s_axis_tuser  <= nxt.act;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // a quarter of the bursts run straight into the next one
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction
    // and drive the receiver's stall pattern
    always @(posedge aclk) begin
        uf_result_t got;
        uf_result_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.set_id      = m_axis_tdata[ID_W-1:0];
                got.same_set    = m_axis_tdata[ID_W];
                got.merged      = m_axis_tdata[ID_W+1];
                got.set_count   = m_axis_tdata[ID_W+2+COUNT_W-1:ID_W+2];
                got.index_error = m_axis_tuser[0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: id %0d same %0b merged %0b count %0d err %0b",
                                 got.set_id, got.same_set, got.merged, got.set_count,
                                 got.index_error);
                end else begin
                    want = expected_results.pop_front();
                    if (got.set_id !== want.set_id || got.same_set !== want.same_set ||
                        got.merged !== want.merged || got.set_count !== want.set_count ||
                        got.index_error !== want.index_error) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected id %0d same %0b merged %0b count %0d",
                                      " err %0b, got id %0d same %0b merged %0b count %0d",
                                      " err %0b"},
                                     want.set_id, want.same_set, want.merged, want.set_count,
                                     want.index_error, got.set_id, got.same_set, got.merged,
                                     got.set_count, got.index_error);
                    end
                end
            end

            // Switch between always ready, coin flip, mostly stalled and long stalls
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 30);
                        m_axis_tready <= (stall_left == 0);
                    end
                endcase
            end
        end
    end

    // Watchdog: a lost or stuck transaction ends the run here
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

`default_nettype wire

### sim.f
design/qfuf_pkg.sv
design/qfuf_ctrl.sv
design/qfuf_datapath.sv
design/quick_find_union_find_unit.sv
bench/quick_find_union_find_unit_test.sv
